FILE: rtl/lgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

	// action codes of an item
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_RUN   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_WRAP   = 2'd2;
	localparam logic [1:0] REG_GENS   = 2'd3;

	localparam int CFG_AW  = 2;
	localparam int CFG_DW  = 16;
	localparam int SIZE_W  = 7;
	localparam int GENS_W  = 16;
	localparam int COORD_W = 6;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 7'd64;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 7'd64;
	localparam logic [GENS_W-1:0] GENS_RST   = 16'd1;

	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

endpackage

`default_nettype wire

FILE: rtl/life_automaton_grid_step.sv
// a cell write or cell read item passes through the states CELL_RD, CELL_WB and FIN from accept to result
// a run item sweeps the grid once per generation for up to g generations, fewer once the grid is stable
// the sweep is bound by the single grid memory: at most one row read and one row written per cycle
// reset sets the configuration and control registers, then a clearing pass writes MAX_HEIGHT rows of dead cells
// no item is accepted during the clearing pass; configuration writes are taken at all times
`timescale 1ns / 1ps
`default_nettype none

module life_automaton_grid_step #(
	parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire  [lgs_pkg::CFG_AW-1:0]   cfg_addr,
	input  wire  [lgs_pkg::CFG_DW-1:0]   cfg_wdata,
	input  wire                          cmd_valid,
	output logic                         cmd_stall,
	input  wire  [1:0]                   action,
	input  wire  [lgs_pkg::COORD_W-1:0]  cell_row,
	input  wire  [lgs_pkg::COORD_W-1:0]  cell_col,
	input  wire                          cell_alive,
	output logic                         rsp_valid,
	input  wire                          rsp_stall,
	output logic                         read_alive,
	output logic [1:0]                   done_action
);

	localparam int AW = $clog2(MAX_HEIGHT);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int SW = $clog2(MAX_HEIGHT + 3);

	localparam logic [2:0] ST_CLR     = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_CELL_RD = 3'd2;
	localparam logic [2:0] ST_CELL_WB = 3'd3;
	localparam logic [2:0] ST_SWEEP   = 3'd4;
	localparam logic [2:0] ST_FIN     = 3'd5;

	// configuration
	logic [lgs_pkg::SIZE_W-1:0] grid_width_q;
	logic [lgs_pkg::SIZE_W-1:0] grid_height_q;
	logic                       wrap_q;
	logic [lgs_pkg::GENS_W-1:0] gens_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= lgs_pkg::WIDTH_RST;
			grid_height_q <= lgs_pkg::HEIGHT_RST;
			wrap_q        <= 1'b0;
			gens_q        <= lgs_pkg::GENS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				lgs_pkg::REG_WIDTH:  grid_width_q  <= cfg_wdata[lgs_pkg::SIZE_W-1:0];
				lgs_pkg::REG_HEIGHT: grid_height_q <= cfg_wdata[lgs_pkg::SIZE_W-1:0];
				lgs_pkg::REG_WRAP:   wrap_q        <= cfg_wdata[0];
				lgs_pkg::REG_GENS:   gens_q        <= cfg_wdata[lgs_pkg::GENS_W-1:0];
				default: ;
			endcase
		end
	end

	// sizes in use, clamped to 1..max
	logic [HW-1:0] h_eff;
	logic [WW-1:0] w_eff;
	logic [CW-1:0] wl;

	always_comb begin
		if (grid_height_q == '0)
			h_eff = HW'(1);
		else if (32'(grid_height_q) > MAX_HEIGHT)
			h_eff = HW'(MAX_HEIGHT);
		else
			h_eff = HW'(grid_height_q);
		if (grid_width_q == '0)
			w_eff = WW'(1);
		else if (32'(grid_width_q) > MAX_WIDTH)
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(grid_width_q);
	end

	assign wl = CW'(w_eff - WW'(1));

	// control and payload registers
	logic [2:0]                  state_q;
	logic [AW-1:0]               clr_q;
	logic [SW-1:0]               step_q;
	logic [lgs_pkg::GENS_W-1:0]  gens_left_q;
	logic                        chg_q;
	logic [1:0]                  act_q;
	logic [AW-1:0]               row_q;
	logic [CW-1:0]               col_q;
	logic                        alive_q;
	logic                        in_range_q;
	logic                        res_bit_q;
	logic                        rsp_valid_q;
	logic                        read_alive_q;
	logic [1:0]                  done_action_q;
	logic [MAX_WIDTH-1:0]        up_q;
	logic [MAX_WIDTH-1:0]        mid_q;
	logic [MAX_WIDTH-1:0]        row0_q;
	logic [MAX_WIDTH-1:0]        rd_data_q;

	// grid memory
	logic [MAX_WIDTH-1:0] grid_mem [MAX_HEIGHT];
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [MAX_WIDTH-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en)
			grid_mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= grid_mem[rd_addr];
	end

	logic cmd_acc;
	logic cmd_in_range;
	logic [SW-1:0] h_s;
	logic last_step;
	logic compute_step;

	assign cmd_stall    = (state_q != ST_IDLE);
	assign cmd_acc      = cmd_valid && !cmd_stall;
	assign cmd_in_range = (32'(cell_row) < 32'(h_eff)) && (32'(cell_col) < 32'(w_eff));
	assign h_s          = SW'(h_eff);
	assign last_step    = (step_q == h_s + SW'(2));
	assign compute_step = (state_q == ST_SWEEP) && (step_q >= SW'(3));

	// one generation: neighbor rows up, mid, dn give the new mid row
	logic [MAX_WIDTH-1:0] dn_row;
	logic [MAX_WIDTH-1:0] new_row;
	logic                 up_last;
	logic                 mid_last;
	logic                 dn_last;
	logic                 row_chg;

	assign dn_row   = last_step ? (wrap_q ? row0_q : '0) : rd_data_q;
	assign up_last  = up_q[wl];
	assign mid_last = mid_q[wl];
	assign dn_last  = dn_row[wl];
	assign row_chg  = |(new_row ^ mid_q);

	for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
		logic ul, ml, dl, ur, mr, dr;
		logic [3:0] n;
		logic nxt;

		if (c == 0) begin : g_left_edge
			assign ul = wrap_q & up_last;
			assign ml = wrap_q & mid_last;
			assign dl = wrap_q & dn_last;
		end else begin : g_left
			assign ul = up_q[c-1];
			assign ml = mid_q[c-1];
			assign dl = dn_row[c-1];
		end

		if (c == MAX_WIDTH - 1) begin : g_right_edge
			assign ur = wrap_q & up_q[0];
			assign mr = wrap_q & mid_q[0];
			assign dr = wrap_q & dn_row[0];
		end else begin : g_right
			assign ur = (CW'(c) == wl) ? (wrap_q & up_q[0])   : up_q[c+1];
			assign mr = (CW'(c) == wl) ? (wrap_q & mid_q[0])  : mid_q[c+1];
			assign dr = (CW'(c) == wl) ? (wrap_q & dn_row[0]) : dn_row[c+1];
		end

		assign n = 4'(ul) + 4'(up_q[c]) + 4'(ur) + 4'(ml) + 4'(mr)
			+ 4'(dl) + 4'(dn_row[c]) + 4'(dr);
		assign nxt = (n == 4'd3) || (mid_q[c] && (n == 4'd2));
		// columns beyond the used width keep their cells
		assign new_row[c] = (WW'(c) < w_eff) ? nxt : mid_q[c];
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = new_row;
		unique case (state_q)
			ST_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_CELL_RD: begin
				rd_en   = 1'b1;
				rd_addr = row_q;
			end
			ST_CELL_WB: begin
				wr_en   = (act_q == lgs_pkg::ACT_WRITE) && in_range_q;
				wr_addr = row_q;
				wr_data = rd_data_q;
				wr_data[col_q] = alive_q;
			end
			ST_SWEEP: begin
				// the last row is fetched first as the upper neighbor of row 0
				rd_en   = (step_q <= h_s);
				rd_addr = (step_q == '0) ? AW'(h_eff - HW'(1)) : AW'(step_q - SW'(1));
				wr_en   = compute_step;
				wr_addr = AW'(step_q - SW'(3));
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			step_q      <= '0;
			gens_left_q <= '0;
			chg_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && (!rsp_valid_q || !rsp_stall))
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_HEIGHT - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_acc) begin
						priority if (action == lgs_pkg::ACT_RUN) begin
							if (gens_q == '0) begin
								state_q <= ST_FIN;
							end else begin
								state_q     <= ST_SWEEP;
								step_q      <= '0;
								gens_left_q <= gens_q;
							end
						end else if (action == lgs_pkg::ACT_WRITE
							|| action == lgs_pkg::ACT_READ) begin
							state_q <= ST_CELL_RD;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_CELL_RD: state_q <= ST_CELL_WB;
				ST_CELL_WB: state_q <= ST_FIN;
				ST_SWEEP: begin
					if (step_q == '0)
						chg_q <= 1'b0;
					else if (compute_step)
						chg_q <= chg_q | row_chg;
					if (last_step) begin
						step_q <= '0;
						// a stable grid stays stable, so the run ends early
						if ((chg_q || row_chg) && gens_left_q != lgs_pkg::GENS_W'(1)) begin
							gens_left_q <= gens_left_q - lgs_pkg::GENS_W'(1);
						end else begin
							gens_left_q <= '0;
							state_q     <= ST_FIN;
						end
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				ST_FIN: begin
					if (!rsp_valid_q || !rsp_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			act_q      <= action;
			row_q      <= AW'(cell_row);
			col_q      <= CW'(cell_col);
			alive_q    <= cell_alive;
			in_range_q <= cmd_in_range;
			res_bit_q  <= 1'b0;
		end
		if (state_q == ST_CELL_WB)
			res_bit_q <= (act_q == lgs_pkg::ACT_READ) && in_range_q && rd_data_q[col_q];
		if (state_q == ST_SWEEP) begin
			if (step_q == SW'(1)) begin
				up_q <= wrap_q ? rd_data_q : '0;
			end else if (step_q == SW'(2)) begin
				mid_q  <= rd_data_q;
				row0_q <= rd_data_q;
			end else if (compute_step) begin
				up_q  <= mid_q;
				mid_q <= rd_data_q;
			end
		end
		if (state_q == ST_FIN && (!rsp_valid_q || !rsp_stall)) begin
			read_alive_q  <= res_bit_q;
			done_action_q <= act_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign read_alive  = read_alive_q;
	assign done_action = done_action_q;

	// checks
	a_sweep_wr_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && wr_en) |-> (32'(wr_addr) < 32'(h_eff)))
		else $error("sweep writes a row outside the used height");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("sweep reads a row in the cycle it is rewritten");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_FIN))
		else $error("result raised outside the finish step");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> (state_q != ST_IDLE))
		else $error("accepted item did not start work");

	a_gens_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (gens_left_q == '0))
		else $error("generation count left over after a run");

endmodule

`default_nettype wire
